[sv/rrfrp_pkg.sv]
// Shared types and constants for the round-robin free register picker.
package rrfrp_pkg;

	localparam int POS_W = 5;
	localparam int MASK_W = 32;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_USABLE_FIXED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USABLE_FLOAT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FIXED    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIXED    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FLOAT    = 3'd4;

	// Reset values
	localparam logic [MASK_W-1:0] RST_USABLE_FIXED = 32'h8300_fffc;
	localparam logic [MASK_W-1:0] RST_USABLE_FLOAT = 32'h0000_03ff;
	localparam logic [POS_W-1:0]  RST_MIN_FIXED    = 5'd2;
	localparam logic [POS_W-1:0]  RST_MAX_FIXED    = 5'd31;
	localparam logic [POS_W-1:0]  RST_MAX_FLOAT    = 5'd9;
	localparam logic [POS_W-1:0]  RST_FIXED_PTR    = 5'd8;
	localparam logic [POS_W-1:0]  RST_FLOAT_PTR    = 5'd0;

	localparam logic MODE_FIXED = 1'b0;
	localparam logic MODE_FLOAT = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [MASK_W-1:0] busy_mask;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] reg_index;
	} res_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last;
	} sts_t;

endpackage

[sv/rrfrp_ctrl.sv]
// Controller state machine: request intake, scan sequencing and result handoff.
module rrfrp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  rrfrp_pkg::sts_t sts,
	output rrfrp_pkg::cmd_t cmd
);
	import rrfrp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				// hold the result until the output register frees up
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_load_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_SCAN))
		else $error("accepted request did not start a scan");

	a_emit_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (out_valid && state_q == ST_IDLE))
		else $error("emitted result not presented");
`endif

endmodule

[sv/rrfrp_dpath.sv]
// Datapath: configuration registers, bank pointers, position walker and result register.
module rrfrp_dpath #(
	parameter int REG_COUNT = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rrfrp_pkg::req_t                  in_data,
	output rrfrp_pkg::res_t                  out_data,
	input  logic                             cfg_wr,
	input  logic [rrfrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rrfrp_pkg::MASK_W-1:0]     cfg_data,
	input  rrfrp_pkg::cmd_t                  cmd,
	output rrfrp_pkg::sts_t                  sts
);
	import rrfrp_pkg::*;

	localparam int CNT_W = (REG_COUNT > 2) ? $clog2(REG_COUNT) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REG_COUNT - 1);

	logic [MASK_W-1:0] usable_fixed_q;
	logic [MASK_W-1:0] usable_float_q;
	logic [POS_W-1:0]  min_fixed_q;
	logic [POS_W-1:0]  max_fixed_q;
	logic [POS_W-1:0]  max_float_q;
	logic [POS_W-1:0]  fixed_ptr_q;
	logic [POS_W-1:0]  float_ptr_q;

	logic              mode_q;
	logic [MASK_W-1:0] busy_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  reg_q;
	logic              chosen_q;
	logic              ptr_ok_q;
	logic [CNT_W-1:0]  cnt_q;
	res_t              res_q;

	logic [MASK_W-1:0] usable;
	logic [POS_W-1:0]  lo;
	logic [POS_W-1:0]  hi;
	logic [POS_W-1:0]  npos;
	logic [POS_W-1:0]  start;
	logic              use_bit;
	logic              free_bit;

	always_comb begin
		usable = (mode_q == MODE_FLOAT) ? usable_float_q : usable_fixed_q;
		lo = (mode_q == MODE_FLOAT) ? '0 : min_fixed_q;
		hi = (mode_q == MODE_FLOAT) ? max_float_q : max_fixed_q;
		npos = (pos_q >= hi) ? lo : pos_q + POS_W'(1);
		use_bit = usable[npos];
		free_bit = !busy_q[npos];
		start = (in_data.mode == MODE_FLOAT) ? float_ptr_q : fixed_ptr_q;
		sts.last = (use_bit && chosen_q) || (cnt_q == CNT_LAST);
	end

	// configuration registers and bank pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_fixed_q <= RST_USABLE_FIXED;
			usable_float_q <= RST_USABLE_FLOAT;
			min_fixed_q <= RST_MIN_FIXED;
			max_fixed_q <= RST_MAX_FIXED;
			max_float_q <= RST_MAX_FLOAT;
			fixed_ptr_q <= RST_FIXED_PTR;
			float_ptr_q <= RST_FLOAT_PTR;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					CFG_USABLE_FIXED: usable_fixed_q <= cfg_data;
					CFG_USABLE_FLOAT: usable_float_q <= cfg_data;
					CFG_MIN_FIXED:    min_fixed_q <= cfg_data[POS_W-1:0];
					CFG_MAX_FIXED:    max_fixed_q <= cfg_data[POS_W-1:0];
					CFG_MAX_FLOAT:    max_float_q <= cfg_data[POS_W-1:0];
					default: begin
					end
				endcase
			end
			// advance the bank pointer only when a usable position followed the pick
			if (cmd.emit && ptr_ok_q) begin
				if (mode_q == MODE_FLOAT) begin
					float_ptr_q <= pos_q;
				end else begin
					fixed_ptr_q <= pos_q;
				end
			end
		end
	end

	// scan control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chosen_q <= 1'b0;
			ptr_ok_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			chosen_q <= !in_data.busy_mask[start];
			ptr_ok_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (use_bit) begin
				if (chosen_q) begin
					ptr_ok_q <= 1'b1;
				end else if (free_bit) begin
					chosen_q <= 1'b1;
				end
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_data.mode;
			busy_q <= in_data.busy_mask;
			pos_q <= start;
			reg_q <= start;
		end else if (cmd.step) begin
			pos_q <= npos;
			if (use_bit && !chosen_q && free_bit) begin
				reg_q <= npos;
			end
		end
		if (cmd.emit) begin
			res_q.found <= chosen_q;
			res_q.reg_index <= chosen_q ? reg_q : '0;
		end
	end

	assign out_data = res_q;

`ifndef SYNTHESIS
	a_ptr_needs_pick: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_ok_q |-> chosen_q)
		else $error("pointer advance flagged without a picked register");

	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (res_q.found || res_q.reg_index == '0))
		else $error("not-found result carries a nonzero index");
`endif

endmodule

[sv/round_robin_free_register_pick_top.sv]
// Sequence: the request is accepted in ST_IDLE, the walker steps in ST_SCAN, and the result is loaded in ST_WAIT.
// Requests do not overlap: in_stall stays high until ST_WAIT hands the result to the output register.
// The scan walker steps one register position per cycle; the bank pointer is read at accept.
// The output register lets a new request be taken while the previous result waits.
// Reset (arst_n low, asynchronous): masks, bounds and pointers return to their defaults.
// Configuration writes are taken every cycle.
module round_robin_free_register_pick_top #(
	parameter int REG_COUNT = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  rrfrp_pkg::req_t                 in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output rrfrp_pkg::res_t                 out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rrfrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rrfrp_pkg::MASK_W-1:0]    cfg_data
);
	import rrfrp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	rrfrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rrfrp_dpath #(
		.REG_COUNT (REG_COUNT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
